[hdl/idl_pkg.sv]
// ----------------------------------------------------------------------------
// idl_pkg
// Shared widths, constants and character helpers for the id link decoder.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int CH_W           = 8;
    localparam int ID_W           = 64;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int POS_W          = 5;
    localparam int PATH_MAX_CHARS = 16;
    localparam int ID_CHARS       = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LEN  = 2'd2;

    localparam logic [CH_W-1:0] CH_LOWER_S = 8'h73;
    localparam logic [6:0]      CV_BAD     = 7'd64;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SCHEME = 6'b000010,
        PH_OPT_S  = 6'b000100,
        PH_PATH   = 6'b001000,
        PH_ID     = 6'b010000,
        PH_TERM   = 6'b100000
    } t_phase;

    function automatic logic [CH_W-1:0] lower_ascii(input logic [CH_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // "http", lower case
    function automatic logic [CH_W-1:0] scheme_char(input logic [1:0] pos);
        logic [CH_W-1:0] c;
        unique case (pos)
            2'd0:    c = 8'h68;
            2'd3:    c = 8'h70;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

    // Base64url digit value, CV_BAD when the byte is not a digit
    function automatic logic [6:0] digit_code(input logic [CH_W-1:0] c);
        logic [6:0] v;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2D) begin
            v = 7'd62;
        end else if (c == 8'h5F) begin
            v = 7'd63;
        end else begin
            v = CV_BAD;
        end
        return v;
    endfunction

endpackage

[hdl/idl_in_if.sv]
// ----------------------------------------------------------------------------
// idl_in_if
// Character channel: one link byte and its first flag per transaction.
// ----------------------------------------------------------------------------
interface idl_in_if
    import idl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            first;

    modport source (output valid, ch, first, input ready);
    modport sink   (input valid, ch, first, output ready);
endinterface

[hdl/idl_out_if.sv]
// ----------------------------------------------------------------------------
// idl_out_if
// Result channel: pass/fail flag and decoded id per transaction.
// ----------------------------------------------------------------------------
interface idl_out_if
    import idl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] id_value;

    modport source (output valid, ok, id_value, input ready);
    modport sink   (input valid, ok, id_value, output ready);
endinterface

[hdl/id_link_decoder.sv]
// ----------------------------------------------------------------------------
// id_link_decoder
// Streams link bytes, matches scheme and path, decodes a base64url 64-bit id.
// ----------------------------------------------------------------------------
// The decoder takes one character per clock and never stalls on its own:
// a character is registered in the character stage on acceptance, evaluated
// against the link state from that stage whenever the output register can
// advance, and any result is registered in the output register, which then
// offers it. Input ready drops only while a result waits in the output
// register and the character stage behind it is full. Each link gives at
// most one result (ok with the id, or a reject); bytes after it are dropped
// until the next character flagged first. Configuration must be written
// through i_cfg_we / i_cfg_index / i_cfg_data only while no link is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module id_link_decoder
    import idl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    idl_in_if.sink                i_in,
    idl_out_if.source             o_out
);

    // Configuration
    logic [63:0]      r_path_low;
    logic [63:0]      r_path_high;
    logic [POS_W-1:0] r_path_len;

    // Character stage
    logic             r_in_valid;
    logic [CH_W-1:0]  r_ch;
    logic             r_first;

    // Link state
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_position, n_position;
    logic [ID_W-1:0]  r_acc, n_acc;

    // Result register
    logic             r_out_valid;
    logic             r_ok;
    logic [ID_W-1:0]  r_id;

    logic             w_advance;
    logic             w_emit;
    logic             w_emit_ok;
    logic [POS_W-1:0] w_len_eff;
    logic [127:0]     w_path_all;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_advance;

    assign w_len_eff  = (r_path_len > POS_W'(PATH_MAX_CHARS)) ?
                        POS_W'(PATH_MAX_CHARS) : r_path_len;
    assign w_path_all = {r_path_high, r_path_low};

    always_comb begin
        t_phase           v_phase;
        logic [POS_W-1:0] v_pos;
        logic [ID_W-1:0]  v_acc;
        logic [CH_W-1:0]  lc;
        logic [CH_W-1:0]  pb;
        logic [6:0]       cv;
        logic             fall;
        logic             fail;

        v_phase   = r_first ? PH_SCHEME : r_phase;
        v_pos     = r_first ? '0 : r_position;
        v_acc     = r_first ? '0 : r_acc;
        lc        = lower_ascii(r_ch);
        cv        = digit_code(r_ch);
        fall      = 1'b0;
        fail      = 1'b0;
        w_emit    = 1'b0;
        w_emit_ok = 1'b0;
        n_phase   = v_phase;
        n_position = v_pos;
        n_acc     = v_acc;

        unique case (v_phase)
            PH_SCHEME: begin
                if (lc != scheme_char(v_pos[1:0])) begin
                    fail = 1'b1;
                end else if (v_pos[1:0] == 2'd3) begin
                    n_phase    = PH_OPT_S;
                    n_position = '0;
                end else begin
                    n_position = v_pos + 1'b1;
                end
            end
            PH_OPT_S: begin
                n_phase    = (w_len_eff == '0) ? PH_ID : PH_PATH;
                n_position = '0;
                // Not an 's': this byte already belongs to the path or the id
                fall       = (lc != CH_LOWER_S);
            end
            PH_PATH, PH_ID: begin
                fall = 1'b1;
            end
            PH_TERM: begin
                w_emit    = 1'b1;
                w_emit_ok = (r_ch == '0);
            end
            default: begin
            end
        endcase

        pb = lower_ascii(w_path_all[{n_position[3:0], 3'b000} +: 8]);

        if (fall) begin
            if (n_phase == PH_PATH) begin
                if (r_ch == '0 || lc != pb) begin
                    fail = 1'b1;
                end else if ((n_position + 1'b1) >= w_len_eff) begin
                    n_phase    = PH_ID;
                    n_position = '0;
                end else begin
                    n_position = n_position + 1'b1;
                end
            end else begin
                if (cv == CV_BAD) begin
                    fail = 1'b1;
                end else if (n_position < POS_W'(ID_CHARS - 1)) begin
                    n_acc      = {n_acc[ID_W-7:0], cv[5:0]};
                    n_position = n_position + 1'b1;
                end else if (cv[5:4] != 2'b00) begin
                    fail = 1'b1;
                end else begin
                    n_acc      = {n_acc[ID_W-5:0], cv[3:0]};
                    n_position = '0;
                    n_phase    = PH_TERM;
                end
            end
        end

        if (fail) begin
            w_emit    = 1'b1;
            w_emit_ok = 1'b0;
        end
        // Drop the link once its outcome is out
        if (w_emit) begin
            n_phase    = PH_IDLE;
            n_position = '0;
            n_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_low  <= '0;
            r_path_high <= '0;
            r_path_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATH_LOW:  r_path_low  <= i_cfg_data;
                CFG_PATH_HIGH: r_path_high <= i_cfg_data;
                CFG_PATH_LEN:  r_path_len  <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch    <= i_in.ch;
            r_first <= i_in.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_position  <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (r_in_valid && w_advance) begin
                r_phase    <= n_phase;
                r_position <= n_position;
                r_acc      <= n_acc;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance && w_emit) begin
            r_ok <= w_emit_ok;
            r_id <= w_emit_ok ? r_acc : '0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.ok       = r_ok;
    assign o_out.id_value = r_id;

    a_reject_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_id == '0)
        else $error("rejected link carries a nonzero id");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_advance && w_emit |=> r_phase == PH_IDLE && r_acc == '0)
        else $error("link state not cleared after its result");

    a_scheme_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SCHEME |-> r_position < POS_W'(4))
        else $error("scheme position out of range");

    a_id_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ID |-> r_position < POS_W'(ID_CHARS))
        else $error("id position out of range");

    a_path_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PATH |-> r_position < w_len_eff)
        else $error("path position beyond configured length");

endmodule
